FILE: rtl/pec_pkg.sv
// Shared types, constants and the CRC byte update for the PEC frame engine.
// No dependencies; imported by every module of the block.
package pec_pkg;

	localparam logic [15:0] PEC_SEED = 16'h0010;

	// Table rows for single-bit indices; the byte table is linear in its index.
	localparam logic [15:0] CRC_BASIS [0:7] = '{
		16'hC599, 16'hCEAB, 16'hD8CF, 16'hF407,
		16'hAD97, 16'h5B2E, 16'hF3C5, 16'hA213
	};

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_ECHO    = 2'd0,
		KIND_GEN_END = 2'd1,
		KIND_CHK_END = 2'd2
	} pec_kind_t;

	typedef enum logic [1:0] {
		PH_BYTE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} pec_phase_t;

	typedef struct packed {
		pec_kind_t   kind;
		logic [7:0]  data;
		logic        ok;
		logic [15:0] pec;
	} pec_entry_t;

	function automatic logic [15:0] crc_update(input logic [15:0] rem, input logic [7:0] b);
		logic [7:0]  idx;
		logic [15:0] acc;
		idx = rem[14:7] ^ b;
		acc = {rem[7:0], 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (idx[k]) begin
				acc = acc ^ CRC_BASIS[k];
			end
		end
		return acc;
	endfunction

endpackage

FILE: rtl/pec_front.sv
// Front end: takes input beats, runs the CRC and classifies each byte.
// Depends on pec_pkg; feeds pec_queue.
module pec_front import pec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	output logic       enq,
	output pec_entry_t enq_entry
);

	logic [15:0] run_rem_q;
	logic [15:0] prev_rem_q;
	logic [7:0]  prev_byte_q;
	logic [1:0]  seen_q;

	logic [15:0] base_rem;
	logic [15:0] base_prev_rem;
	logic [7:0]  base_prev_byte;
	logic [1:0]  base_seen;
	logic [15:0] new_rem;
	logic [1:0]  new_seen;
	logic [15:0] chk_pec;

	assign enq = push && !full;

	always_comb begin
		base_rem       = first_byte ? PEC_SEED : run_rem_q;
		base_prev_rem  = first_byte ? PEC_SEED : prev_rem_q;
		base_prev_byte = first_byte ? 8'h00 : prev_byte_q;
		base_seen      = first_byte ? 2'd0 : seen_q;
		new_rem        = crc_update(base_rem, data_byte);
		new_seen       = (base_seen == 2'd3) ? 2'd3 : base_seen + 2'd1;
		chk_pec        = {base_prev_rem[14:0], 1'b0};

		enq_entry.data = data_byte;
		enq_entry.ok   = 1'b0;
		enq_entry.pec  = {new_rem[14:0], 1'b0};
		enq_entry.kind = KIND_ECHO;
		if (last_byte) begin
			if (cmd) begin
				enq_entry.kind = KIND_CHK_END;
				enq_entry.pec  = chk_pec;
				enq_entry.ok   = (new_seen == 2'd3) && ({base_prev_byte, data_byte} == chk_pec);
			end else begin
				enq_entry.kind = KIND_GEN_END;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_rem_q   <= PEC_SEED;
			prev_rem_q  <= PEC_SEED;
			prev_byte_q <= 8'h00;
			seen_q      <= 2'd0;
		end else if (enq) begin
			if (last_byte) begin
				run_rem_q   <= PEC_SEED;
				prev_rem_q  <= PEC_SEED;
				prev_byte_q <= 8'h00;
				seen_q      <= 2'd0;
			end else begin
				run_rem_q   <= new_rem;
				prev_rem_q  <= base_rem;
				prev_byte_q <= data_byte;
				seen_q      <= new_seen;
			end
		end
	end

endmodule

FILE: rtl/pec_queue.sv
// Short queue of classified entries between front and back ends.
// Depends on pec_pkg.
module pec_queue import pec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       enq,
	input  pec_entry_t enq_entry,
	input  logic       deq,
	output pec_entry_t head,
	output logic       full,
	output logic       empty
);

	pec_entry_t             slot_q [0:QUEUE_DEPTH-1];
	logic [QUEUE_AW-1:0]    wr_ptr_q;
	logic [QUEUE_AW-1:0]    rd_ptr_q;
	logic [QUEUE_CW-1:0]    count_q;

	localparam logic [QUEUE_AW-1:0] PTR_LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_CW-1:0] COUNT_FULL = QUEUE_CW'(QUEUE_DEPTH);

	logic do_deq;

	assign full   = (count_q == COUNT_FULL);
	assign empty  = (count_q == '0);
	assign head   = slot_q[rd_ptr_q];
	assign do_deq = deq && !empty;

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= enq_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_deq) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (enq && !do_deq) begin
				count_q <= count_q + 1'b1;
			end else if (!enq && do_deq) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("queue count beyond depth");

	a_enq_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(enq && !do_deq) |=> !empty)
		else $error("queue empty after lone enqueue");

endmodule

FILE: rtl/pec_back.sv
// Back end: expands queued entries into result beats, appending PEC bytes.
// Depends on pec_pkg; reads the head of pec_queue.
module pec_back import pec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  pec_entry_t  head,
	input  logic        q_empty,
	input  logic        pop,
	output logic        deq,
	output logic [7:0]  out_byte,
	output logic        is_pec_byte,
	output logic        frame_done,
	output logic        pec_ok,
	output logic [15:0] pec_word
);

	pec_phase_t phase_q;
	pec_phase_t phase_d;
	logic       take;

	assign take = pop && !q_empty;

	always_comb begin
		phase_d     = phase_q;
		deq         = 1'b0;
		out_byte    = head.data;
		is_pec_byte = 1'b0;
		frame_done  = 1'b0;
		pec_ok      = head.ok;
		pec_word    = head.pec;
		unique case (phase_q)
			PH_BYTE: begin
				frame_done = (head.kind == KIND_CHK_END);
				if (take) begin
					if (head.kind == KIND_GEN_END) begin
						phase_d = PH_HIGH;
					end else begin
						deq = 1'b1;
					end
				end
			end
			PH_HIGH: begin
				out_byte    = head.pec[15:8];
				is_pec_byte = 1'b1;
				if (take) begin
					phase_d = PH_LOW;
				end
			end
			PH_LOW: begin
				out_byte    = head.pec[7:0];
				is_pec_byte = 1'b1;
				frame_done  = 1'b1;
				if (take) begin
					phase_d = PH_BYTE;
					deq     = 1'b1;
				end
			end
			default: begin
				phase_d = PH_BYTE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BYTE;
		end else begin
			phase_q <= phase_d;
		end
	end

	a_phase_gen_only: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_BYTE) |-> (!q_empty && head.kind == KIND_GEN_END))
		else $error("append phase without a generate entry");

	a_echo_single: assert property (@(posedge clk) disable iff (!arst_n)
		(take && phase_q == PH_BYTE && head.kind != KIND_GEN_END) |=> phase_q == PH_BYTE)
		else $error("single-beat entry left append phase");

	a_deq_only_taken: assert property (@(posedge clk) disable iff (!arst_n)
		deq |-> (take && (phase_q == PH_LOW || head.kind != KIND_GEN_END)))
		else $error("entry dropped before all beats delivered");

endmodule

FILE: rtl/pec_crc15_frame_engine.sv
// Top level of the 15-bit PEC frame generator and checker.
// Depends on pec_pkg, pec_front, pec_queue and pec_back.
//
// Input channel: push/full. A byte beat with cmd, data_byte, first_byte and
// last_byte is taken at an edge with push high and full low; one per cycle.
// Result channel: empty/pop. The oldest result sits on the result ports while
// empty is low and is taken at an edge with pop high.
// Each byte gives one result; a generate-mode last byte gives three (the echo
// then the PEC high and low bytes). A check-mode last byte carries frame_done
// and pec_ok. pec_word is the running PEC, or the payload PEC at frame end.
// A result is written into a queue slot before it reaches the result ports.
// Throughput: one byte per cycle in unless full, one result per cycle out when
// popped and not empty; the front end's CRC update is one table XOR per byte.
// A four-entry queue separates front and back: input keeps flowing while the
// receiver stalls, and full rises once four bytes are waiting.
// Reset: remainders return to the 0x0010 seed, the queue empties.
module pec_crc15_frame_engine import pec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        is_pec_byte,
	output logic        frame_done,
	output logic        pec_ok,
	output logic [15:0] pec_word
);

	logic       enq;
	pec_entry_t enq_entry;
	logic       deq;
	pec_entry_t head;

	pec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.cmd        (cmd),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.enq        (enq),
		.enq_entry  (enq_entry)
	);

	pec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq       (enq),
		.enq_entry (enq_entry),
		.deq       (deq),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	pec_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (empty),
		.pop         (pop),
		.deq         (deq),
		.out_byte    (out_byte),
		.is_pec_byte (is_pec_byte),
		.frame_done  (frame_done),
		.pec_ok      (pec_ok),
		.pec_word    (pec_word)
	);

endmodule
